@@ src/cva_pkg.sv @@
`timescale 1ns / 1ps

package cva_pkg;

    // default geometry and coefficient size
    localparam int CVA_MAX_WIDTH  = 1024;
    localparam int CVA_MAX_HEIGHT = 1024;
    localparam int CVA_COEF_BITS  = 8;

    // fixed field widths
    localparam int PIX_W     = 8;
    localparam int MAG_W     = 19;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // largest magnitude the result field holds
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // result queue depth
    localparam int FIFO_DEPTH = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_KTOP   = 3'd2,
        REG_KMID   = 3'd3,
        REG_KBOT   = 3'd4
    } t_cfg_reg;

    // per-item control handed to a window cell
    typedef struct packed {
        logic calc;
        logic acc;
        logic top_off;
        logic bot_off;
        logic col_off;
    } t_cell_ctl;

    // bits needed to index n entries
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // config data width: widest of the geometry and kernel registers
    function automatic int cfg_w(input int coef_bits);
        return (3 * coef_bits > DIM_W) ? 3 * coef_bits : DIM_W;
    endfunction

endpackage

@@ src/cva_if.sv @@
`timescale 1ns / 1ps

// pixel item channel
interface cva_in_if import cva_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output action, output pixel, input ready);
    modport sink (input valid, input action, input pixel, output ready);
endinterface

// result item channel
interface cva_out_if import cva_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;

    modport source (output valid, output magnitude, output frame_end, input ready);
    modport sink (input valid, input magnitude, input frame_end, output ready);
endinterface

@@ src/cva_cell.sv @@
`timescale 1ns / 1ps

module cva_cell import cva_pkg::*; #(
    parameter int COEF_BITS = CVA_COEF_BITS,
    parameter int PROD_W    = COEF_BITS + PIX_W + 1,
    parameter int SUM_W     = PROD_W + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic [3*PIX_W-1:0]      i_col,
    input  logic [3*COEF_BITS-1:0]  i_coef,
    input  t_cell_ctl               i_ctl,
    output logic [3*PIX_W-1:0]      o_col,
    output logic signed [SUM_W-1:0] o_sum
);

    logic [PIX_W-1:0]         r_pix [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] w_prod [3];
    logic signed [SUM_W-1:0]  r_sum;

    // window column, shifted in from the right neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) r_pix[r] <= '0;
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) r_pix[r] <= i_col[r*PIX_W +: PIX_W];
        end
    end

    assign o_col = {r_pix[2], r_pix[1], r_pix[0]};

    // weighted taps, zeroed where the neighbor lies outside the frame
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (i_ctl.col_off || (r == 0 && i_ctl.top_off) || (r == 2 && i_ctl.bot_off)) begin
                w_prod[r] = '0;
            end else begin
                w_prod[r] = $signed({1'b0, r_pix[r]}) * $signed(i_coef[r*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    // product and column sum stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            for (int r = 0; r < 3; r++) r_prod[r] <= w_prod[r];
        end
        if (i_ctl.acc) begin
            r_sum <= {{2{r_prod[0][PROD_W-1]}}, r_prod[0]}
                   + {{2{r_prod[1][PROD_W-1]}}, r_prod[1]}
                   + {{2{r_prod[2][PROD_W-1]}}, r_prod[2]};
        end
    end

    assign o_sum = r_sum;

endmodule

@@ src/cva_line_store.sv @@
`timescale 1ns / 1ps

module cva_line_store import cva_pkg::*; #(
    parameter int DEPTH  = CVA_MAX_WIDTH,
    parameter int ADDR_W = idx_w(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]  i_wr_pix,
    output logic [PIX_W-1:0]  o_up,
    output logic [PIX_W-1:0]  o_mid,
    output logic              o_clr_busy
);

    logic [PIX_W-1:0]  mem_up  [DEPTH];
    logic [PIX_W-1:0]  mem_mid [DEPTH];
    logic [PIX_W-1:0]  r_rd_up;
    logic [PIX_W-1:0]  r_rd_mid;
    logic [PIX_W-1:0]  r_fwd_up;
    logic [PIX_W-1:0]  r_fwd_mid;
    logic              r_fwd;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // read data corrected for a write to the same column in the same cycle as the read
    assign o_up  = r_fwd ? r_fwd_up  : r_rd_up;
    assign o_mid = r_fwd ? r_fwd_mid : r_rd_mid;

    // both line memories: clearing sweep, then column rotate on write
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_up[r_clr_addr]  <= '0;
            mem_mid[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem_up[i_wr_addr]  <= o_mid;
            mem_mid[i_wr_addr] <= i_wr_pix;
        end
        if (i_rd_en) begin
            r_rd_up   <= mem_up[i_rd_addr];
            r_rd_mid  <= mem_mid[i_rd_addr];
            r_fwd_up  <= o_mid;
            r_fwd_mid <= i_wr_pix;
        end
    end

    // forward flag and clearing sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_rd_en) begin
                r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
            if (r_clr_busy) begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                end
            end
        end
    end

    assign o_clr_busy = r_clr_busy;

endmodule

@@ src/cva_out_fifo.sv @@
`timescale 1ns / 1ps

module cva_out_fifo import cva_pkg::*; #(
    parameter int DEPTH  = FIFO_DEPTH,
    parameter int DATA_W = MAG_W + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full
);

    localparam int PTR_W = idx_w(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = mem[r_rd_ptr];

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/conv3x3_abs_zero_pad.sv @@
`timescale 1ns / 1ps

// Streaming 3x3 convolution magnitude with zero padding. Pixels enter in raster
// order, one per clock while the input is ready, and each leaves as |sum of
// kernel times neighborhood|, with neighbors outside the frame taken as zero. A
// result is due width+1 items after its pixel, so the host sends width+1 flush
// items after a frame; the last result carries frame_end and all counters
// restart. Inside, a pixel reads the two line memories at acceptance, its column
// shifts into a chain of three window cells in the next cycle, the cells register
// their products and then their column sums, and a final adder, absolute value
// and saturation put the result into an 8-entry queue. The block takes one item
// every clock as long as fewer than 8 results are pending. After reset the line
// memories are cleared one column per cycle, so no item is taken until the
// clearing sweep is done; configuration writes are taken at any time and must
// only change while the block is idle.
module conv3x3_abs_zero_pad import cva_pkg::*; #(
    parameter int MAX_WIDTH  = CVA_MAX_WIDTH,
    parameter int MAX_HEIGHT = CVA_MAX_HEIGHT,
    parameter int COEF_BITS  = CVA_COEF_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cfg_w(COEF_BITS)-1:0] i_cfg_data,
    cva_in_if.sink                      i_in,
    cva_out_if.source                   o_out
);

    localparam int COL_W  = idx_w(MAX_WIDTH);
    localparam int ROW_W  = idx_w(MAX_HEIGHT);
    localparam int WB_W   = $clog2(MAX_WIDTH + 1);
    localparam int HB_W   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (WB_W > DIM_W) ? WB_W : DIM_W;
    localparam int HCMP_W = (HB_W > DIM_W) ? HB_W : DIM_W;
    localparam int KROW_W = 3 * COEF_BITS;
    localparam int PROD_W = COEF_BITS + PIX_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TOT_W  = SUM_W + 2;
    localparam int ABS_W  = (TOT_W > MAG_W) ? TOT_W : MAG_W;
    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

    // input row position, saturating once two rows are in
    typedef enum logic [1:0] {
        ROW_FIRST,
        ROW_SECOND,
        ROW_LATER
    } t_in_row;

    // per-item control travelling down the pipeline
    typedef struct packed {
        logic go;
        logic last;
        logic top_off;
        logic bot_off;
        logic left_off;
        logic right_off;
    } t_stage;

    function automatic t_in_row row_inc(input t_in_row r);
        return (r == ROW_FIRST) ? ROW_SECOND : ROW_LATER;
    endfunction

    // configuration
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [KROW_W-1:0] r_kernel [3];
    logic [WCMP_W-1:0] w_lim;
    logic [HCMP_W-1:0] h_lim;

    // position counters
    t_in_row          r_in_row, n_in_row;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // acceptance stage
    logic             w_acc;
    logic             w_clr_busy;
    logic [PIX_W-1:0] w_x;
    logic [COL_W-1:0] s0_col;
    t_stage           s0_info;

    // pipeline
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] r_s1_x;
    t_stage           r_st1, r_st2, r_st3, r_st4, r_st5;
    logic signed [TOT_W-1:0] r_total;

    // window chain
    logic [PIX_W-1:0]         w_up;
    logic [PIX_W-1:0]         w_mid;
    logic [3*PIX_W-1:0]       w_col2_in;
    logic [3*PIX_W-1:0]       w_col1_in;
    logic [3*PIX_W-1:0]       w_col0_in;
    logic [KROW_W-1:0]        w_coef [3];
    t_cell_ctl                w_ctl [3];
    logic signed [SUM_W-1:0]  w_sum [3];

    // result path
    logic [TOT_W-1:0]  w_abs;
    logic [ABS_W-1:0]  w_abs_ext;
    logic [MAG_W-1:0]  w_mag;
    logic              w_push;
    logic              w_pop;
    logic              w_fifo_full;
    logic [MAG_W:0]    w_fifo_out;
    logic [PEND_W-1:0] r_pending;

    // effective geometry, clamped to 1..max
    always_comb begin
        if (r_width == '0) begin
            w_lim = WCMP_W'(1);
        end else if (WCMP_W'(r_width) > WCMP_W'(MAX_WIDTH)) begin
            w_lim = WCMP_W'(MAX_WIDTH);
        end else begin
            w_lim = WCMP_W'(r_width);
        end
        if (r_height == '0) begin
            h_lim = HCMP_W'(1);
        end else if (HCMP_W'(r_height) > HCMP_W'(MAX_HEIGHT)) begin
            h_lim = HCMP_W'(MAX_HEIGHT);
        end else begin
            h_lim = HCMP_W'(r_height);
        end
    end

    assign w_acc = i_in.valid && i_in.ready;
    assign w_x   = i_in.action ? '0 : i_in.pixel;
    assign i_in.ready = !w_clr_busy && (r_pending < PEND_W'(FIFO_DEPTH));

    // item position, result due flag, padding masks and next counters
    always_comb begin
        logic             wrap_in;
        logic             wrap_out;
        t_in_row          row0;
        logic [COL_W:0]   col_inc;
        logic             emit;
        logic [COL_W-1:0] oc;
        logic [ROW_W-1:0] orow;
        logic             oc_end;
        logic             or_end;
        logic             last;

        wrap_in  = WCMP_W'(r_in_col) >= w_lim;
        s0_col   = wrap_in ? '0 : r_in_col;
        row0     = wrap_in ? row_inc(r_in_row) : r_in_row;
        emit     = (row0 == ROW_LATER) || (row0 == ROW_SECOND && s0_col != '0);
        col_inc  = {1'b0, s0_col} + (COL_W + 1)'(1);
        wrap_out = WCMP_W'(col_inc) >= w_lim;

        oc     = (WCMP_W'(r_out_col) >= w_lim) ? COL_W'(w_lim - WCMP_W'(1)) : r_out_col;
        orow   = (HCMP_W'(r_out_row) >= h_lim) ? ROW_W'(h_lim - HCMP_W'(1)) : r_out_row;
        oc_end = (WCMP_W'(oc) + WCMP_W'(1)) >= w_lim;
        or_end = (HCMP_W'(orow) + HCMP_W'(1)) >= h_lim;
        last   = oc_end && or_end;

        s0_info.go        = w_acc && emit;
        s0_info.last      = last;
        s0_info.top_off   = (orow == '0);
        s0_info.bot_off   = or_end;
        s0_info.left_off  = (oc == '0);
        s0_info.right_off = oc_end;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_acc) begin
            n_in_col = wrap_out ? '0 : col_inc[COL_W-1:0];
            n_in_row = wrap_out ? row_inc(row0) : row0;
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = ROW_FIRST;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (oc_end) begin
                    n_out_col = '0;
                    n_out_row = orow + ROW_W'(1);
                end else begin
                    n_out_col = oc + COL_W'(1);
                    n_out_row = orow;
                end
            end
        end
    end

    // configuration registers, counters and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_kernel   <= '{default: '0};
            r_in_col   <= '0;
            r_in_row   <= ROW_FIRST;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_st1      <= '0;
            r_st2      <= '0;
            r_st3      <= '0;
            r_st4      <= '0;
            r_st5      <= '0;
            r_pending  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_WIDTH:  r_width     <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT: r_height    <= i_cfg_data[DIM_W-1:0];
                    REG_KTOP:   r_kernel[0] <= i_cfg_data[KROW_W-1:0];
                    REG_KMID:   r_kernel[1] <= i_cfg_data[KROW_W-1:0];
                    REG_KBOT:   r_kernel[2] <= i_cfg_data[KROW_W-1:0];
                    default:    r_width     <= r_width;
                endcase
            end
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= w_acc;
            r_st1      <= s0_info;
            r_st2      <= r_st1;
            r_st3      <= r_st2;
            r_st4      <= r_st3;
            r_st5      <= r_st4;
            case ({s0_info.go, w_pop})
                2'b10:   r_pending <= r_pending + PEND_W'(1);
                2'b01:   r_pending <= r_pending - PEND_W'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

    // item payload into the line stage, final sum
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_col <= s0_col;
            r_s1_x   <= w_x;
        end
        if (r_st4.go) begin
            r_total <= {{2{w_sum[0][SUM_W-1]}}, w_sum[0]}
                     + {{2{w_sum[1][SUM_W-1]}}, w_sum[1]}
                     + {{2{w_sum[2][SUM_W-1]}}, w_sum[2]};
        end
    end

    // line memories: read at acceptance, rotated in the next cycle
    cva_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_lines (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_acc),
        .i_rd_addr  (s0_col),
        .i_wr_en    (r_s1_valid),
        .i_wr_addr  (r_s1_col),
        .i_wr_pix   (r_s1_x),
        .o_up       (w_up),
        .o_mid      (w_mid),
        .o_clr_busy (w_clr_busy)
    );

    // kernel columns and cell control
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_coef[c] = {r_kernel[2][c*COEF_BITS +: COEF_BITS],
                         r_kernel[1][c*COEF_BITS +: COEF_BITS],
                         r_kernel[0][c*COEF_BITS +: COEF_BITS]};
            w_ctl[c].calc    = r_st2.go;
            w_ctl[c].acc     = r_st3.go;
            w_ctl[c].top_off = r_st2.top_off;
            w_ctl[c].bot_off = r_st2.bot_off;
        end
        w_ctl[0].col_off = r_st2.left_off;
        w_ctl[1].col_off = 1'b0;
        w_ctl[2].col_off = r_st2.right_off;
    end

    // newest column enters the right cell
    assign w_col2_in = {r_s1_x, w_mid, w_up};

    cva_cell #(.COEF_BITS(COEF_BITS)) u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col2_in),
        .i_coef  (w_coef[2]),
        .i_ctl   (w_ctl[2]),
        .o_col   (w_col1_in),
        .o_sum   (w_sum[2])
    );

    cva_cell #(.COEF_BITS(COEF_BITS)) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col1_in),
        .i_coef  (w_coef[1]),
        .i_ctl   (w_ctl[1]),
        .o_col   (w_col0_in),
        .o_sum   (w_sum[1])
    );

    cva_cell #(.COEF_BITS(COEF_BITS)) u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col0_in),
        .i_coef  (w_coef[0]),
        .i_ctl   (w_ctl[0]),
        .o_col   (),
        .o_sum   (w_sum[0])
    );

    // absolute value and saturation
    always_comb begin
        w_abs     = r_total[TOT_W-1] ? TOT_W'(-r_total) : TOT_W'(r_total);
        w_abs_ext = ABS_W'(w_abs);
        w_mag     = (w_abs_ext > ABS_W'(MAG_MAX)) ? MAG_MAX : w_abs_ext[MAG_W-1:0];
    end

    assign w_push = r_st5.go;
    assign w_pop  = o_out.valid && o_out.ready;

    // result queue
    cva_out_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .DATA_W (MAG_W + 1)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({r_st5.last, w_mag}),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_fifo_out),
        .o_full  (w_fifo_full)
    );

    assign o_out.magnitude = w_fifo_out[MAG_W-1:0];
    assign o_out.frame_end = w_fifo_out[MAG_W];

    // pending results never exceed the queue
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(FIFO_DEPTH))
        else $error("pending result count above queue depth");

    // no item taken while the line memories are cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !i_in.ready)
        else $error("item accepted during line memory clear");

    // a result never arrives at a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_full)
        else $error("result pushed into full queue");

    // frame end restarts the input position
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_info.go && s0_info.last) |=> (r_in_col == '0 && r_in_row == ROW_FIRST))
        else $error("input position not restarted after frame end");

endmodule
